[design/ale_pkg.sv]
// Package for the array list engine: command and result word types,
// opcode, status and sequencer state encodings, and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_PREPEND      = 3'd1,
        OP_INSERT_AT    = 3'd2,
        OP_REMOVE_LAST  = 3'd3,
        OP_REMOVE_FIRST = 3'd4,
        OP_REMOVE_AT    = 3'd5,
        OP_FIND         = 3'd6,
        OP_OVERWRITE    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_CLOSE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [3:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic       found;
        logic [3:0] match_index;
        logic [4:0] count;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

[design/array_list_engine.sv]
// Array list engine: an ordered list of words in a memory with one read and one write port,
// shifted and searched one entry per cycle by a small sequencer; a search also waits on a stalled result port.
// Depends on ale_pkg.
//
// Channel  Dir  Handshake                  Word
// cmd      in   i_cmd_valid / o_cmd_ready  ale_pkg::t_cmd
// res      out  o_res_valid / i_res_ready  ale_pkg::t_result
//
// A command is taken only while the sequencer is idle, one at a time.
// Remove-last, overwrite and rejected commands go straight to the result; append, prepend
// and insert pass through an open state that shifts entries up, a removal of the first or a given
// entry through a close state that shifts them down, and find through a scan, with one memory read and write per cycle.
// Reset clears the entry count; entry contents need no clearing.
// A stalled result port holds the sequencer wherever a new result is due.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine #(
    parameter int DEPTH     = ale_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ale_pkg::WORD_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_ready,
    input  wire ale_pkg::t_cmd   i_cmd,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output ale_pkg::t_result     o_res
);
    import ale_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [CW-1:0] C_DEPTH = CW'(DEPTH);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [WORD_BITS-1:0] r_word, n_word;
    t_status              r_status, n_status;
    logic [AW-1:0]        r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    logic                 r_rd_ok, n_rd_ok;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 out_load;

    logic                 cmd_acc, out_free;
    logic                 is_full, is_empty, pos_bad;
    logic [CW-1:0]        cmd_pos;
    logic [WORD_BITS-1:0] cmd_word;
    logic                 open_more, close_more, scan_more;
    logic [CW-1:0]        open_nx, close_nx;
    logic                 match, scan_stall;

    assign cmd_acc    = i_cmd_valid && o_cmd_ready;
    assign out_free   = !r_out_valid || i_res_ready;
    assign is_full    = (r_count == C_DEPTH);
    assign is_empty   = (r_count == '0);
    assign pos_bad    = (PW'(i_cmd.position) >= PW'(r_count));
    assign cmd_pos    = CW'(i_cmd.position);
    assign cmd_word   = WORD_BITS'(i_cmd.value);
    assign open_more  = (r_idx > r_pos);
    assign open_nx    = r_rd_ok ? (r_idx - C_ONE) : r_idx;
    assign close_more = ((r_idx + C_ONE) < r_count);
    assign close_nx   = r_rd_ok ? (r_idx + C_ONE) : r_idx;
    assign scan_more  = (r_idx < r_count);
    assign match      = (r_rd_data == r_word);
    assign scan_stall = r_rd_ok && match && r_pend_v && !out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.op)
                        OP_APPEND, OP_PREPEND: n_state = is_full ? S_DONE : S_OPEN;
                        OP_INSERT_AT: n_state = (is_full || pos_bad) ? S_DONE : S_OPEN;
                        OP_REMOVE_FIRST: n_state = is_empty ? S_DONE : S_CLOSE;
                        OP_REMOVE_AT: n_state = (is_empty || pos_bad) ? S_DONE : S_CLOSE;
                        OP_FIND: n_state = S_SCAN;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_OPEN: begin
                if (!open_more) begin
                    n_state = S_DONE;
                end
            end
            S_CLOSE: begin
                if (!close_more) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (!scan_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_word    = r_word;
        n_status  = r_status;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_rd_ok   = r_rd_ok;
        rd_en     = 1'b0;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_rd_data;
        out_load  = 1'b0;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_word   = cmd_word;
                    n_status = ST_OK;
                    n_pend   = '0;
                    n_pend_v = 1'b0;
                    n_rd_ok  = 1'b0;
                    case (i_cmd.op)
                        OP_APPEND: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end
                            n_idx = r_count;
                            n_pos = r_count;
                        end
                        OP_PREPEND: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end
                            n_idx = r_count;
                            n_pos = '0;
                        end
                        OP_INSERT_AT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (pos_bad) begin
                                n_status = ST_RANGE;
                            end
                            n_idx = r_count;
                            n_pos = cmd_pos;
                        end
                        OP_REMOVE_LAST: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - C_ONE;
                            end
                        end
                        OP_REMOVE_FIRST: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end
                            n_idx = '0;
                        end
                        OP_REMOVE_AT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                n_status = ST_RANGE;
                            end
                            n_idx = cmd_pos;
                        end
                        OP_FIND: begin
                            n_idx = '0;
                        end
                        default: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(cmd_pos);
                                mem_wdata = cmd_word;
                            end
                        end
                    endcase
                end
            end
            S_OPEN: begin
                if (open_more) begin
                    if (r_rd_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_idx);
                        n_idx     = open_nx;
                    end
                    if (open_nx > r_pos) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(open_nx - C_ONE);
                        n_rd_ok = 1'b1;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_pos);
                    mem_wdata = r_word;
                    n_count   = r_count + C_ONE;
                end
            end
            S_CLOSE: begin
                if (close_more) begin
                    if (r_rd_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_idx);
                        n_idx     = close_nx;
                    end
                    if ((close_nx + C_ONE) < r_count) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(close_nx + C_ONE);
                        n_rd_ok = 1'b1;
                    end
                end else begin
                    n_count = r_count - C_ONE;
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    if (!r_rd_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_idx);
                        n_rd_ok = 1'b1;
                    end else if (!scan_stall) begin
                        if (match && r_pend_v) begin
                            out_load          = 1'b1;
                            n_out.status      = ST_OK;
                            n_out.found       = 1'b1;
                            n_out.match_index = 4'(r_pend);
                            n_out.count       = 5'(r_count);
                            n_out.last        = 1'b0;
                        end
                        if (match) begin
                            n_pend   = AW'(r_idx);
                            n_pend_v = 1'b1;
                        end
                        n_idx = r_idx + C_ONE;
                        if ((r_idx + C_ONE) < r_count) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_idx + C_ONE);
                        end else begin
                            n_rd_ok = 1'b0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.status      = r_status;
                    n_out.found       = r_pend_v;
                    n_out.match_index = 4'(r_pend);
                    n_out.count       = 5'(r_count);
                    n_out.last        = 1'b1;
                end
            end
            default: begin
                n_rd_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_ok     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_ok  <= n_rd_ok;
            r_pend_v <= n_pend_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_status <= n_status;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_DEPTH)
        else $error("entry count exceeds depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CW'(mem_waddr) <= r_count))
        else $error("memory write beyond the end of the list");

    a_partial_only_in_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == S_SCAN || r_state == S_DONE))
        else $error("non-final result outside a find");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> $stable(r_out))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
